/* hdl/ddec_pkg.sv */
// ----------------------------------------------------------------------------
// ddec_pkg
// Shared types and constants of the detection anchor decoder.
// ----------------------------------------------------------------------------
package ddec_pkg;

	localparam int FEAT_W = 24;

	localparam logic [7:0] MAX_CLASSES   = 8'd128;
	localparam logic [5:0] MAX_KEYPOINTS = 6'd32;

	localparam logic signed [FEAT_W-1:0] SCORE_MINUS_ONE = -24'sd256;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [2:0] CFG_NUM_CLASSES     = 3'd0;
	localparam logic [2:0] CFG_POSE_MODE       = 3'd1;
	localparam logic [2:0] CFG_SCORE_THRESHOLD = 3'd2;
	localparam logic [2:0] CFG_SCALE_FACTOR    = 3'd3;
	localparam logic [2:0] CFG_IMAGE_WIDTH     = 3'd4;
	localparam logic [2:0] CFG_IMAGE_HEIGHT    = 3'd5;
	localparam logic [2:0] CFG_KEYPOINT_COUNT  = 3'd6;

	localparam logic KIND_BOX      = 1'b0;
	localparam logic KIND_KEYPOINT = 1'b1;

	typedef struct packed {
		logic [7:0]  num_classes;
		logic        pose_mode;
		logic [8:0]  score_threshold;
		logic [23:0] scale_factor;
		logic [13:0] image_width;
		logic [13:0] image_height;
		logic [5:0]  keypoint_count;
	} cfg_t;

	// box: v0..v3 = center x, center y, width, height
	// keypoint: v0 = x, v1 = y, v2 = keypoint score
	typedef struct packed {
		logic                     kind;
		logic [15:0]              anchor;
		logic [6:0]               label;
		logic signed [FEAT_W-1:0] score;
		logic signed [FEAT_W-1:0] v0;
		logic signed [FEAT_W-1:0] v1;
		logic signed [FEAT_W-1:0] v2;
		logic signed [FEAT_W-1:0] v3;
		logic [4:0]               kidx;
	} job_t;

endpackage

/* hdl/ddec_front.sv */
// ----------------------------------------------------------------------------
// ddec_front
// Feature tracker: counts positions within an anchor, keeps the running
// best score, and issues a box or keypoint job when a result is due.
// ----------------------------------------------------------------------------
module ddec_front #(
	parameter int MAX_ANCHORS = 65536
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ddec_pkg::cfg_t                    cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [ddec_pkg::FEAT_W-1:0] feature_value,
	input  logic                              last_feature,
	output logic                              job_valid,
	input  logic                              job_ready,
	output ddec_pkg::job_t                    job
);

	localparam int AW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
	localparam logic [AW-1:0] ANCHOR_LAST = AW'(MAX_ANCHORS - 1);

	logic [7:0]                          pos_q;
	logic [AW-1:0]                       anchor_q;
	logic signed [ddec_pkg::FEAT_W-1:0]  best_q;
	logic [6:0]                          label_q;
	logic                                acc_q;
	logic signed [ddec_pkg::FEAT_W-1:0]  cs_q [4];
	logic signed [ddec_pkg::FEAT_W-1:0]  kx_q;
	logic signed [ddec_pkg::FEAT_W-1:0]  ky_q;
	logic [1:0]                          ph_q;
	logic [6:0]                          kcnt_q;

	logic signed [ddec_pkg::FEAT_W-1:0]  best_d;
	logic [6:0]                          label_d;
	logic                                acc_d;
	logic [1:0]                          ph_d;
	logic [6:0]                          kcnt_d;
	logic                                emit;
	logic                                accept;
	logic [7:0]                          nc;
	logic [5:0]                          kc;
	logic [8:0]                          cls_stop;
	logic [8:0]                          cls_end;
	logic                                beat;
	logic signed [ddec_pkg::FEAT_W-1:0]  new_best;
	logic [7:0]                          lbl_diff;
	logic signed [ddec_pkg::FEAT_W-1:0]  thr;

	assign in_ready = job_ready;
	assign accept   = in_valid && in_ready;
	assign job_valid = in_valid && emit;

	always_comb begin
		if (cfg.num_classes == 8'd0) begin
			nc = 8'd1;
		end else if (cfg.num_classes > ddec_pkg::MAX_CLASSES) begin
			nc = ddec_pkg::MAX_CLASSES;
		end else begin
			nc = cfg.num_classes;
		end
		if (cfg.keypoint_count > ddec_pkg::MAX_KEYPOINTS) begin
			kc = ddec_pkg::MAX_KEYPOINTS;
		end else begin
			kc = cfg.keypoint_count;
		end
	end

	assign cls_stop = {1'b0, nc} + 9'd4;
	assign cls_end  = {1'b0, nc} + 9'd3;
	assign beat     = feature_value > best_q;
	assign new_best = beat ? feature_value : best_q;
	assign lbl_diff = pos_q - 8'd4;
	assign thr      = $signed({15'd0, cfg.score_threshold});

	always_comb begin
		best_d  = best_q;
		label_d = label_q;
		acc_d   = acc_q;
		emit    = 1'b0;
		job        = '0;
		job.anchor = 16'(anchor_q);
		job.v0     = cs_q[0];
		job.v1     = cs_q[1];
		job.v2     = cs_q[2];
		job.v3     = cs_q[3];
		job.kind   = ddec_pkg::KIND_BOX;
		if (pos_q < 8'd4) begin
			emit = 1'b0;
		end else if (!cfg.pose_mode) begin
			if ({1'b0, pos_q} < cls_stop) begin
				best_d  = new_best;
				label_d = beat ? lbl_diff[6:0] : label_q;
				if ({1'b0, pos_q} == cls_end && new_best > thr) begin
					acc_d = 1'b1;
					emit  = 1'b1;
				end
			end
		end else if (pos_q == 8'd4) begin
			best_d  = feature_value;
			label_d = 7'd0;
			if (feature_value > thr) begin
				acc_d = 1'b1;
				emit  = 1'b1;
			end
		end else if (kcnt_q < {1'b0, kc}) begin
			if (ph_q == 2'd2 && acc_q) begin
				emit     = 1'b1;
				job.kind = ddec_pkg::KIND_KEYPOINT;
				job.v0   = kx_q;
				job.v1   = ky_q;
				job.v2   = feature_value;
				job.v3   = '0;
				job.kidx = kcnt_q[4:0];
			end
		end
		job.score = (job.kind == ddec_pkg::KIND_BOX) ? best_d : best_q;
		job.label = (job.kind == ddec_pkg::KIND_BOX) ? label_d : 7'd0;
	end

	always_comb begin
		ph_d   = ph_q;
		kcnt_d = kcnt_q;
		if (pos_q == 8'd4) begin
			ph_d   = 2'd0;
			kcnt_d = 7'd0;
		end else if (pos_q > 8'd4 && pos_q < 8'd255) begin
			ph_d   = (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
			kcnt_d = (ph_q == 2'd2) ? kcnt_q + 7'd1 : kcnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 8'd0;
			anchor_q <= '0;
			best_q   <= ddec_pkg::SCORE_MINUS_ONE;
			label_q  <= 7'd0;
			acc_q    <= 1'b0;
		end else if (accept) begin
			if (last_feature) begin
				pos_q    <= 8'd0;
				anchor_q <= (anchor_q == ANCHOR_LAST) ? '0 : anchor_q + AW'(1);
				best_q   <= ddec_pkg::SCORE_MINUS_ONE;
				label_q  <= 7'd0;
				acc_q    <= 1'b0;
			end else begin
				if (pos_q < 8'd255) begin
					pos_q <= pos_q + 8'd1;
				end
				best_q  <= best_d;
				label_q <= label_d;
				acc_q   <= acc_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (pos_q < 8'd4) begin
				cs_q[pos_q[1:0]] <= feature_value;
			end
			if (cfg.pose_mode && pos_q > 8'd4 && kcnt_q < {1'b0, kc}) begin
				if (ph_q == 2'd0) begin
					kx_q <= feature_value;
				end
				if (ph_q == 2'd1) begin
					ky_q <= feature_value;
				end
			end
			ph_q   <= ph_d;
			kcnt_q <= kcnt_d;
		end
	end

endmodule

/* hdl/ddec_queue.sv */
// ----------------------------------------------------------------------------
// ddec_queue
// Short job queue between the feature tracker and the geometry pipeline.
// ----------------------------------------------------------------------------
module ddec_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  ddec_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output ddec_pkg::job_t pop_job
);

	ddec_pkg::job_t                  slot_q [ddec_pkg::QUEUE_DEPTH];
	logic [ddec_pkg::QUEUE_AW-1:0]   wr_q;
	logic [ddec_pkg::QUEUE_AW-1:0]   rd_q;
	logic [ddec_pkg::QUEUE_AW:0]     count_q;
	logic                            push;
	logic                            pop;

	assign push_ready = count_q < (ddec_pkg::QUEUE_AW + 1)'(ddec_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_job    = slot_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + ddec_pkg::QUEUE_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + ddec_pkg::QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (ddec_pkg::QUEUE_AW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (ddec_pkg::QUEUE_AW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

endmodule

/* hdl/ddec_back.sv */
// ----------------------------------------------------------------------------
// ddec_back
// Geometry pipeline: corner operands, four scale multipliers, clamp to the
// image, then truncation into the result register.
// ----------------------------------------------------------------------------
module ddec_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ddec_pkg::cfg_t                     cfg,
	input  logic                               job_valid,
	output logic                               job_ready,
	input  ddec_pkg::job_t                     job,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               result_kind,
	output logic [15:0]                        anchor_index,
	output logic [6:0]                         class_label,
	output logic signed [ddec_pkg::FEAT_W-1:0] score,
	output logic [13:0]                        box_x,
	output logic [13:0]                        box_y,
	output logic [13:0]                        box_width,
	output logic [13:0]                        box_height,
	output logic [4:0]                         keypoint_index,
	output logic [21:0]                        keypoint_x,
	output logic [21:0]                        keypoint_y,
	output logic signed [ddec_pkg::FEAT_W-1:0] keypoint_score
);

	logic                en;
	logic                valid_s1, valid_s2, valid_s3, out_valid_q;
	ddec_pkg::job_t      meta_s1, meta_s2, meta_s3;
	logic signed [25:0]  op_d  [4];
	logic signed [25:0]  op_s1 [4];
	logic signed [50:0]  prod_s2 [4];
	logic [39:0]         clamp_d  [4];
	logic [39:0]         clamp_s3 [4];
	logic signed [25:0]  twox, twoy, wext, hext;
	logic [39:0]         bnd_w, bnd_h;
	logic [40:0]         dw, dh;

	assign en        = !out_valid_q || out_ready;
	assign job_ready = en;
	assign out_valid = out_valid_q;

	assign twox = {job.v0[23], job.v0, 1'b0};
	assign twoy = {job.v1[23], job.v1, 1'b0};
	assign wext = {{2{job.v2[23]}}, job.v2};
	assign hext = {{2{job.v3[23]}}, job.v3};

	always_comb begin
		if (job.kind == ddec_pkg::KIND_BOX) begin
			op_d[0] = twox - wext;
			op_d[1] = twox + wext;
			op_d[2] = twoy - hext;
			op_d[3] = twoy + hext;
		end else begin
			op_d[0] = {{2{job.v0[23]}}, job.v0};
			op_d[1] = '0;
			op_d[2] = {{2{job.v1[23]}}, job.v1};
			op_d[3] = '0;
		end
	end

	always_comb begin
		if (meta_s2.kind == ddec_pkg::KIND_BOX) begin
			bnd_w = {1'b0, cfg.image_width, 25'd0};
			bnd_h = {1'b0, cfg.image_height, 25'd0};
		end else begin
			bnd_w = {2'b0, cfg.image_width, 24'd0};
			bnd_h = {2'b0, cfg.image_height, 24'd0};
		end
		for (int i = 0; i < 4; i++) begin
			if (prod_s2[i] < 0) begin
				clamp_d[i] = '0;
			end else if (i < 2 && prod_s2[i] > $signed({11'd0, bnd_w})) begin
				clamp_d[i] = bnd_w;
			end else if (i >= 2 && prod_s2[i] > $signed({11'd0, bnd_h})) begin
				clamp_d[i] = bnd_h;
			end else begin
				clamp_d[i] = prod_s2[i][39:0];
			end
		end
	end

	assign dw = {1'b0, clamp_s3[1]} - {1'b0, clamp_s3[0]};
	assign dh = {1'b0, clamp_s3[3]} - {1'b0, clamp_s3[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= job_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= job;
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			for (int i = 0; i < 4; i++) begin
				op_s1[i]    <= op_d[i];
				prod_s2[i]  <= op_s1[i] * $signed({1'b0, cfg.scale_factor});
				clamp_s3[i] <= clamp_d[i];
			end
			result_kind  <= meta_s3.kind;
			anchor_index <= meta_s3.anchor;
			class_label  <= meta_s3.label;
			score        <= meta_s3.score;
			if (meta_s3.kind == ddec_pkg::KIND_BOX) begin
				box_x          <= clamp_s3[0][38:25];
				box_y          <= clamp_s3[2][38:25];
				box_width      <= dw[40] ? 14'd0 : dw[38:25];
				box_height     <= dh[40] ? 14'd0 : dh[38:25];
				keypoint_index <= 5'd0;
				keypoint_x     <= 22'd0;
				keypoint_y     <= 22'd0;
				keypoint_score <= '0;
			end else begin
				box_x          <= 14'd0;
				box_y          <= 14'd0;
				box_width      <= 14'd0;
				box_height     <= 14'd0;
				keypoint_index <= meta_s3.kidx;
				keypoint_x     <= clamp_s3[0][37:16];
				keypoint_y     <= clamp_s3[2][37:16];
				keypoint_score <= meta_s3.v2;
			end
		end
	end

endmodule

/* hdl/detection_anchor_decoder_core.sv */
// ----------------------------------------------------------------------------
// detection_anchor_decoder_core
// Anchor box decoder for a detector head: class argmax or objectness, box
// and keypoint scaling and clamping to the image.
// ----------------------------------------------------------------------------
// Takes one feature per cycle and produces at most one result per feature.
// The front tracker handles each feature combinationally against its
// registered state; due results pass through a four-item queue into a
// pipeline of three stages plus the result register (corner operands, 26x25
// scale multipliers, clamp, then truncation). Throughput is one item per
// cycle as long as results are taken; a stalled result port backs up the
// queue and then holds off input.
// The user must write configuration through cfg_write/cfg_index/cfg_data
// only while no results are outstanding; the block itself does not enforce it.
module detection_anchor_decoder_core #(
	parameter int MAX_ANCHORS = 65536
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [2:0]                         cfg_index,
	input  logic [23:0]                        cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [ddec_pkg::FEAT_W-1:0] feature_value,
	input  logic                               last_feature,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               result_kind,
	output logic [15:0]                        anchor_index,
	output logic [6:0]                         class_label,
	output logic signed [ddec_pkg::FEAT_W-1:0] score,
	output logic [13:0]                        box_x,
	output logic [13:0]                        box_y,
	output logic [13:0]                        box_width,
	output logic [13:0]                        box_height,
	output logic [4:0]                         keypoint_index,
	output logic [21:0]                        keypoint_x,
	output logic [21:0]                        keypoint_y,
	output logic signed [ddec_pkg::FEAT_W-1:0] keypoint_score
);

	ddec_pkg::cfg_t cfg_q;
	ddec_pkg::job_t front_job, back_job;
	logic           front_valid, front_ready;
	logic           back_valid, back_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_classes     <= 8'd80;
			cfg_q.pose_mode       <= 1'b0;
			cfg_q.score_threshold <= 9'd64;
			cfg_q.scale_factor    <= 24'd65536;
			cfg_q.image_width     <= 14'd640;
			cfg_q.image_height    <= 14'd640;
			cfg_q.keypoint_count  <= 6'd17;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ddec_pkg::CFG_NUM_CLASSES:     cfg_q.num_classes     <= cfg_data[7:0];
				ddec_pkg::CFG_POSE_MODE:       cfg_q.pose_mode       <= cfg_data[0];
				ddec_pkg::CFG_SCORE_THRESHOLD: cfg_q.score_threshold <= cfg_data[8:0];
				ddec_pkg::CFG_SCALE_FACTOR:    cfg_q.scale_factor    <= cfg_data;
				ddec_pkg::CFG_IMAGE_WIDTH:     cfg_q.image_width     <= cfg_data[13:0];
				ddec_pkg::CFG_IMAGE_HEIGHT:    cfg_q.image_height    <= cfg_data[13:0];
				ddec_pkg::CFG_KEYPOINT_COUNT:  cfg_q.keypoint_count  <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	ddec_front #(
		.MAX_ANCHORS(MAX_ANCHORS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.feature_value(feature_value),
		.last_feature (last_feature),
		.job_valid    (front_valid),
		.job_ready    (front_ready),
		.job          (front_job)
	);

	ddec_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(front_valid),
		.push_ready(front_ready),
		.push_job  (front_job),
		.pop_valid (back_valid),
		.pop_ready (back_ready),
		.pop_job   (back_job)
	);

	ddec_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.job_valid     (back_valid),
		.job_ready     (back_ready),
		.job           (back_job),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.anchor_index  (anchor_index),
		.class_label   (class_label),
		.score         (score),
		.box_x         (box_x),
		.box_y         (box_y),
		.box_width     (box_width),
		.box_height    (box_height),
		.keypoint_index(keypoint_index),
		.keypoint_x    (keypoint_x),
		.keypoint_y    (keypoint_y),
		.keypoint_score(keypoint_score)
	);

endmodule
